// File: sv/assert_macros.svh
// assertion helpers used by the top-level transcoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define UTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define UTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/utf16u_pkg.sv
package utf16u_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LONE_LOW  = 3'd1;
  localparam logic [2:0] ST_UNPAIRED  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_ENDS_HIGH = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            done;
    logic [2:0]      status;
  } job_t;

  function automatic enc_t encode(input logic [20:0] cp);
    enc_t r;
    r.bytes = '0;
    if (cp <= 21'h00007F) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp < 21'h010000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

// File: sv/utf16_to_utf8_strict_transcoder.sv
// UTF-16 to UTF-8 transcoder with strict surrogate checking. One code unit is
// taken per input item; each result carries at most one UTF-8 byte, and the last
// result of a string carries string_done and the status (nonzero means the
// name must be discarded). The front end classifies a unit and updates the
// string state in the cycle it is accepted, so it takes an item every cycle
// while its two-entry queue has room. The back end sends one result per cycle
// while the receiver is ready, and an item makes one result per byte it yields:
// none for a held high surrogate, 1 to 3 for a single unit, 4 for a surrogate
// pair, one without a byte for a closing item with no bytes. The first result
// of an item passes through the queue and then the result register; the result
// stage accepts a new byte in the same cycle the previous one is taken.
`include "assert_macros.svh"

module utf16_to_utf8_strict_transcoder #(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        unit_present_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  utf8_byte_o,
  output logic        byte_present_o,
  output logic        run_last_o,
  output logic        string_done_o,
  output logic [2:0]  status_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  utf16u_pkg::job_t job_in;
  utf16u_pkg::job_t job_head;

  utf16u_front #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .unit_present_i (unit_present_i),
    .string_end_i   (string_end_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  utf16u_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (job_head)
  );

  utf16u_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (head_valid),
    .job_i          (job_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .utf8_byte_o    (utf8_byte_o),
    .byte_present_o (byte_present_o),
    .run_last_o     (run_last_o),
    .string_done_o  (string_done_o),
    .status_o       (status_o)
  );

  `UTF_ASSERT(a_done_last, out_valid_o && string_done_o |-> run_last_o, "done off run end")
  `UTF_ASSERT(a_empty_done, out_valid_o && !byte_present_o |-> string_done_o, "empty mid string")
  `UTF_ASSERT(a_st_done, out_valid_o && !string_done_o |-> status_o == utf16u_pkg::ST_OK, "bad status")
  `UTF_ASSERT(a_no_push_full, full |-> !push, "push while full")
  `UTF_ASSERT_ALWAYS(a_st_range, out_valid_o |-> status_o <= utf16u_pkg::ST_EMPTY, "status range")

endmodule

// File: sv/utf16u_front.sv
module utf16u_front #(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        code_unit_i,
  input  logic               unit_present_i,
  input  logic               string_end_i,
  input  logic               full_i,
  output logic               push_o,
  output utf16u_pkg::job_t   job_o
);

  localparam int unsigned CntW = $clog2(MAX_NAME_BYTES + 1);

  logic [9:0]      pending_q, pending_d;
  logic            waiting_q, waiting_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic [2:0]      err_q, err_d;

  logic            accept;
  logic            is_high;
  logic            is_low;
  logic            have_cp;
  logic [20:0]     cp;
  utf16u_pkg::enc_t enc;
  logic [CntW:0]   sum;
  logic [2:0]      cnt;
  logic [2:0]      status;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_high    = code_unit_i[15:10] == 6'b110110;
  assign is_low     = code_unit_i[15:10] == 6'b110111;
  assign cp         = waiting_q ? 21'h010000 + {1'b0, pending_q, code_unit_i[9:0]}
                                : {5'd0, code_unit_i};
  assign enc        = utf16u_pkg::encode(cp);
  assign sum        = {1'b0, emitted_q} + (CntW + 1)'(enc.cnt);

  always_comb begin
    pending_d = pending_q;
    waiting_d = waiting_q;
    emitted_d = emitted_q;
    err_d     = err_q;
    have_cp   = 1'b0;
    cnt       = 3'd0;
    status    = utf16u_pkg::ST_OK;
    if (unit_present_i && err_q == utf16u_pkg::ST_OK) begin
      if (waiting_q) begin
        waiting_d = 1'b0;
        pending_d = '0;
        if (!is_low) begin
          err_d = utf16u_pkg::ST_UNPAIRED;
        end else begin
          have_cp = 1'b1;
        end
      end else if (is_high) begin
        pending_d = code_unit_i[9:0];
        waiting_d = 1'b1;
      end else if (is_low) begin
        err_d = utf16u_pkg::ST_LONE_LOW;
      end else begin
        have_cp = 1'b1;
      end
      if (have_cp) begin
        if (sum > (CntW + 1)'(MAX_NAME_BYTES)) begin
          err_d = utf16u_pkg::ST_TOO_LONG;
        end else begin
          cnt       = enc.cnt;
          emitted_d = sum[CntW-1:0];
        end
      end
    end
    if (string_end_i) begin
      status = err_d;
      if (err_d == utf16u_pkg::ST_OK) begin
        if (waiting_d) begin
          status = utf16u_pkg::ST_ENDS_HIGH;
        end else if (emitted_d == '0) begin
          status = utf16u_pkg::ST_EMPTY;
        end
      end
      pending_d = '0;
      waiting_d = 1'b0;
      emitted_d = '0;
      err_d     = utf16u_pkg::ST_OK;
    end
  end

  assign push_o       = accept && (cnt != 3'd0 || string_end_i);
  assign job_o.bytes  = enc.bytes;
  assign job_o.cnt    = cnt;
  assign job_o.done   = string_end_i;
  assign job_o.status = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      waiting_q <= 1'b0;
      emitted_q <= '0;
      err_q     <= utf16u_pkg::ST_OK;
    end else if (accept) begin
      pending_q <= pending_d;
      waiting_q <= waiting_d;
      emitted_q <= emitted_d;
      err_q     <= err_d;
    end
  end

endmodule

// File: sv/utf16u_fifo.sv
module utf16u_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf16u_pkg::job_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output utf16u_pkg::job_t data_o
);

  localparam int unsigned Depth = utf16u_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  utf16u_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/utf16u_back.sv
module utf16u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  utf16u_pkg::job_t job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       utf8_byte_o,
  output logic             byte_present_o,
  output logic             run_last_o,
  output logic             string_done_o,
  output logic [2:0]       status_o
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx;
  logic       last;
  logic       load;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       present_q, run_last_q, done_q;
  logic [2:0] status_q;

  assign last_idx = (job_i.cnt == 3'd0) ? 2'd0 : 2'(job_i.cnt - 3'd1);
  assign last     = idx_q == last_idx;
  assign load     = valid_i && (!valid_q || out_ready_i);
  assign pop_o    = load && last;
  assign idx_d    = last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      present_q  <= job_i.cnt != 3'd0;
      byte_q     <= (job_i.cnt != 3'd0) ? job_i.bytes[idx_q] : 8'd0;
      run_last_q <= last;
      done_q     <= last && job_i.done;
      status_q   <= (last && job_i.done) ? job_i.status : utf16u_pkg::ST_OK;
    end
  end

  assign out_valid_o    = valid_q;
  assign utf8_byte_o    = byte_q;
  assign byte_present_o = present_q;
  assign run_last_o     = run_last_q;
  assign string_done_o  = done_q;
  assign status_o       = status_q;

endmodule

// File: dv/utf8_stream_checker.sv
module utf8_stream_checker #(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        unit_present_i,
  input  logic        string_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  utf8_byte_i,
  input  logic        byte_present_i,
  input  logic        run_last_i,
  input  logic        string_done_i,
  input  logic [2:0]  status_i,
  output int          mismatch_cnt_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       present;
    logic       run_last;
    logic       done;
    logic [2:0] status;
  } utf8_result_t;

  utf8_result_t expected_bytes_q[$];

  logic [9:0] held_high;
  logic       high_held;
  int         name_bytes;
  logic [2:0] first_err;
  int         mismatches;

  task automatic transcode_unit(input logic [15:0] cu, input logic present, input logic fin);
    logic [20:0]  cp;
    logic [7:0]   enc[4];
    int           n;
    logic         have_cp;
    logic [2:0]   st;
    utf8_result_t r;
    n       = 0;
    have_cp = 1'b0;
    cp      = {5'd0, cu};
    st      = utf16u_pkg::ST_OK;
    foreach (enc[i]) enc[i] = 8'h00;
    if (present && first_err == utf16u_pkg::ST_OK) begin
      if (high_held) begin
        high_held = 1'b0;
        if (cu < 16'hDC00 || cu > 16'hDFFF) begin
          first_err = utf16u_pkg::ST_UNPAIRED;
        end else begin
          cp      = 21'h10000 + {1'b0, held_high, cu[9:0]};
          have_cp = 1'b1;
        end
        held_high = '0;
      end else if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
        held_high = cu[9:0];
        high_held = 1'b1;
      end else if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
        first_err = utf16u_pkg::ST_LONE_LOW;
      end else begin
        have_cp = 1'b1;
      end
      if (have_cp) begin
        if (cp <= 21'h7F) begin
          enc[0] = cp[7:0];
          n      = 1;
        end else if (cp <= 21'h7FF) begin
          enc[0] = 8'hC0 | cp[10:6];
          enc[1] = 8'h80 | cp[5:0];
          n      = 2;
        end else if (cp < 21'h10000) begin
          enc[0] = 8'hE0 | cp[15:12];
          enc[1] = 8'h80 | cp[11:6];
          enc[2] = 8'h80 | cp[5:0];
          n      = 3;
        end else begin
          enc[0] = 8'hF0 | cp[20:18];
          enc[1] = 8'h80 | cp[17:12];
          enc[2] = 8'h80 | cp[11:6];
          enc[3] = 8'h80 | cp[5:0];
          n      = 4;
        end
        if (name_bytes + n > MAX_NAME_BYTES) begin
          first_err = utf16u_pkg::ST_TOO_LONG;
          n         = 0;
        end else begin
          name_bytes += n;
        end
      end
    end
    if (fin) begin
      st = first_err;
      if (st == utf16u_pkg::ST_OK) begin
        if (high_held) st = utf16u_pkg::ST_ENDS_HIGH;
        else if (name_bytes == 0) st = utf16u_pkg::ST_EMPTY;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.byte_val = enc[k];
      r.present  = 1'b1;
      r.run_last = (k == n - 1);
      r.done     = fin && (k == n - 1);
      r.status   = (fin && k == n - 1) ? st : utf16u_pkg::ST_OK;
      expected_bytes_q.insert(expected_bytes_q.size(), r);
    end
    if (fin && n == 0) begin
      r = '{byte_val: 8'h00, present: 1'b0, run_last: 1'b1, done: 1'b1, status: st};
      expected_bytes_q.insert(expected_bytes_q.size(), r);
    end
    if (fin) begin
      held_high  = '0;
      high_held  = 1'b0;
      name_bytes = 0;
      first_err  = utf16u_pkg::ST_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8_result_t want;
    utf8_result_t got;
    if (!rst_ni) begin
      expected_bytes_q.delete();
      held_high      = '0;
      high_held      = 1'b0;
      name_bytes     = 0;
      first_err      = utf16u_pkg::ST_OK;
      mismatches     = 0;
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{byte_val: utf8_byte_i, present: byte_present_i, run_last: run_last_i,
                done: string_done_i, status: status_i};
        if (expected_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte=%02h present=%0b last=%0b done=%0b st=%0d",
                     $time, got.byte_val, got.present, got.run_last, got.done, got.status);
        end else begin
          want = expected_bytes_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch exp byte=%02h present=%0b last=%0b done=%0b st=%0d",
                     $time, want.byte_val, want.present, want.run_last, want.done,
                     want.status);
              $display(" | got byte=%02h present=%0b last=%0b done=%0b st=%0d",
                       got.byte_val, got.present, got.run_last, got.done, got.status);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        transcode_unit(code_unit_i, unit_present_i, string_end_i);
      outstanding_o  <= expected_bytes_q.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

// File: dv/tb_utf16_to_utf8_strict_transcoder.sv
module tb_utf16_to_utf8_strict_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NameLimit = 255;

  typedef struct packed {
    logic [15:0] cu;
    logic        present;
    logic        fin;
  } utf16_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit = '0;
  logic        unit_present = 1'b0;
  logic        string_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  utf8_byte;
  logic        byte_present;
  logic        run_last;
  logic        string_done;
  logic [2:0]  status;
  int          mismatch_cnt;
  int          outstanding;

  utf16_item_t name_q[$];
  int          items_sent = 0;
  int          item_target;
  bit          burst = 1'b0;
  int          stall_left = 0;
  int          calm_left = 0;

  utf16_to_utf8_strict_transcoder #(
    .MAX_NAME_BYTES(NameLimit)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .code_unit_i   (code_unit),
    .unit_present_i(unit_present),
    .string_end_i  (string_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .utf8_byte_o   (utf8_byte),
    .byte_present_o(byte_present),
    .run_last_o    (run_last),
    .string_done_o (string_done),
    .status_o      (status)
  );

  utf8_stream_checker #(
    .MAX_NAME_BYTES(NameLimit)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .code_unit_i   (code_unit),
    .unit_present_i(unit_present),
    .string_end_i  (string_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .utf8_byte_i   (utf8_byte),
    .byte_present_i(byte_present),
    .run_last_i    (run_last),
    .string_done_i (string_done),
    .status_i      (status),
    .mismatch_cnt_o(mismatch_cnt),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: short stalls, a few long ones, and calm stretches
  always @(posedge clk) begin
    int r;
    if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
      end else if (r < 90) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else if (r < 97) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(5, 25);
      end else begin
        out_ready <= 1'b1;
        calm_left = $urandom_range(20, 80);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [15:0] rand_unit(input logic [15:0] lo, input logic [15:0] hi);
    return 16'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  task automatic add(input logic [15:0] cu, input logic present, input logic fin);
    utf16_item_t it;
    it = '{cu: cu, present: present, fin: fin};
    name_q.insert(name_q.size(), it);
  endtask

  task automatic send_item(input utf16_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    code_unit    <= it.cu;
    unit_present <= it.present;
    string_end   <= it.fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_name();
    burst = ($urandom_range(0, 3) == 0);
    foreach (name_q[i]) send_item(name_q[i]);
    name_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [15:0] three_byte_unit();
    if ($urandom_range(0, 1) == 0) return rand_unit(16'h0800, 16'hD7FF);
    return rand_unit(16'hE000, 16'hFFFF);
  endfunction

  task automatic add_random_name();
    int len;
    int r;
    if ($urandom_range(0, 19) == 0) len = 0;
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 30);
    else len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add(rand_unit(16'h0000, 16'h007F), 1'b1, 1'b0);
      end else if (r < 40) begin
        add(rand_unit(16'h0080, 16'h07FF), 1'b1, 1'b0);
      end else if (r < 55) begin
        add(three_byte_unit(), 1'b1, 1'b0);
      end else if (r < 75) begin
        add(rand_unit(16'hD800, 16'hDBFF), 1'b1, 1'b0);
        add(rand_unit(16'hDC00, 16'hDFFF), 1'b1, 1'b0);
      end else if (r < 80) begin
        add(rand_unit(16'hDC00, 16'hDFFF), 1'b1, 1'b0);
      end else if (r < 85) begin
        add(rand_unit(16'hD800, 16'hDBFF), 1'b1, 1'b0);
      end else if (r < 90) begin
        add(rand_unit(16'h0000, 16'hFFFF), 1'b0, 1'b0);
      end else begin
        add(rand_unit(16'h0000, 16'hFFFF), 1'b1, 1'b0);
      end
    end
    if (name_q.size() == 0 || $urandom_range(0, 9) == 0)
      add(rand_unit(16'h0000, 16'hFFFF), 1'b0, 1'b1);
    else
      name_q[name_q.size() - 1].fin = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty name, then a name of a single NUL unit
    add(16'h0000, 1'b0, 1'b1);
    send_name();
    add(16'h0000, 1'b1, 1'b1);
    send_name();
    // encoding length boundaries
    add(16'h007F, 1'b1, 1'b0);
    add(16'h0080, 1'b1, 1'b0);
    add(16'h07FF, 1'b1, 1'b0);
    add(16'h0800, 1'b1, 1'b0);
    add(16'hFFFF, 1'b1, 1'b1);
    send_name();
    // lowest and highest surrogate pairs
    add(16'hD800, 1'b1, 1'b0);
    add(16'hDC00, 1'b1, 1'b0);
    add(16'hDBFF, 1'b1, 1'b0);
    add(16'hDFFF, 1'b1, 1'b1);
    send_name();
    // lone low surrogate, later units dropped
    add(16'h0041, 1'b1, 1'b0);
    add(16'hDFFF, 1'b1, 1'b0);
    add(16'h0042, 1'b1, 1'b1);
    send_name();
    // high surrogate followed by a plain unit, then by another high
    add(16'hD800, 1'b1, 1'b0);
    add(16'h0041, 1'b1, 1'b1);
    send_name();
    add(16'hDBFF, 1'b1, 1'b0);
    add(16'hD800, 1'b1, 1'b1);
    send_name();
    // ends on a held high, with an idle item in between
    add(16'h0041, 1'b1, 1'b0);
    add(16'hFFFF, 1'b0, 1'b0);
    add(16'hD800, 1'b1, 1'b1);
    send_name();
    add(16'hDBFF, 1'b1, 1'b1);
    send_name();
    // closing item without a unit after bytes
    add(16'h00E9, 1'b1, 1'b0);
    add(16'h5555, 1'b0, 1'b1);
    send_name();
    wait_drained();

    item_target = 370;

    // exactly at the byte limit
    for (int i = 0; i < 85; i++) add(three_byte_unit(), 1'b1, i == 84);
    send_name();
    wait_drained();
    // pair crosses the byte limit
    for (int i = 0; i < 84; i++) add(three_byte_unit(), 1'b1, 1'b0);
    add(rand_unit(16'hD800, 16'hDBFF), 1'b1, 1'b0);
    add(rand_unit(16'hDC00, 16'hDFFF), 1'b1, 1'b0);
    add(16'h0061, 1'b1, 1'b0);
    add(16'h0062, 1'b1, 1'b1);
    send_name();

    while (items_sent < item_target) begin
      add_random_name();
      send_name();
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    wait_drained();
    repeat (24) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
